[design/ilt_pkg.sv]
// Shared package of the INI line tokenizer: character codes, token and event codes,
// and the struct that carries one input word between the input stage and the parser.
// No dependencies.
`default_nettype none

package ilt_pkg;

  localparam logic [7:0] CharLBracket = 8'h5B;
  localparam logic [7:0] CharRBracket = 8'h5D;
  localparam logic [7:0] CharEquals   = 8'h3D;
  localparam logic [7:0] CharComma    = 8'h2C;
  localparam logic [7:0] CharSQuote   = 8'h27;
  localparam logic [7:0] CharDQuote   = 8'h22;
  localparam logic [7:0] CharNewline  = 8'h0A;
  localparam logic [7:0] CharTab      = 8'h09;
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharNul      = 8'h00;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindSection = 2'd1,
    KindKey     = 2'd2,
    KindValue   = 2'd3
  } token_kind_e;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvSection = 3'd1,
    EvKey     = 3'd2,
    EvSep     = 3'd3,
    EvValue   = 3'd4,
    EvError   = 3'd5
  } event_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_start;
    logic       section_line;
  } item_t;

endpackage

`default_nettype wire

[design/ilt_in_stage.sv]
// Input register stage of the INI line tokenizer.
// Holds one accepted word until the parser takes it; depends on ilt_pkg.
`default_nettype none

module ilt_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ilt_pkg::item_t in_item_i,
  output logic               item_valid_o,
  input  wire logic          item_ready_i,
  output ilt_pkg::item_t     item_o
);

  logic           valid_q;
  ilt_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

[design/ilt_parser.sv]
// Line parse state machine and result register of the INI line tokenizer.
// Decodes one word per cycle against the parse state while the result register is free or read; depends on ilt_pkg.
`default_nettype none

module ilt_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  wire ilt_pkg::item_t item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          token_kind_o,
  output logic [7:0]          token_byte_o,
  output logic [2:0]          event_res_o,
  output logic                line_done_o,
  output logic                error_flag_o
);

  typedef enum logic [3:0] {
    StDone     = 4'd0,
    StSecHead  = 4'd2,
    StSecStart = 4'd3,
    StSecName  = 4'd4,
    StKeyStart = 4'd5,
    StKey      = 4'd6,
    StVal      = 4'd7,
    StValSq    = 4'd8,
    StValDq    = 4'd9
  } state_e;

  state_e               state_q, state_d, cur_state;
  logic                 err_q, err_d;
  logic                 out_valid_q;
  ilt_pkg::token_kind_e kind_q, kind_d;
  logic [7:0]           byte_q, byte_d;
  ilt_pkg::event_e      ev_q, ev_d;
  logic                 done_q;
  logic [7:0]           c;
  logic                 eol, blank, fail, fire;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign c            = item_i.char_in;
  assign eol          = (c == ilt_pkg::CharNul) || (c == ilt_pkg::CharNewline);
  assign blank        = (c == ilt_pkg::CharSpace) || (c == ilt_pkg::CharTab);

  always_comb begin
    cur_state = item_i.line_start ? (item_i.section_line ? StSecHead : StKeyStart) : state_q;
    err_d     = item_i.line_start ? 1'b0 : err_q;
    state_d   = cur_state;
    kind_d    = ilt_pkg::KindNone;
    byte_d    = 8'd0;
    ev_d      = ilt_pkg::EvNone;
    fail      = 1'b0;
    case (cur_state)
      StSecHead: begin
        if (c == ilt_pkg::CharLBracket) begin
          state_d = StSecHead;
        end else if (c == ilt_pkg::CharRBracket || eol) begin
          fail = 1'b1;
        end else if (blank) begin
          state_d = StSecStart;
        end else begin
          state_d = StSecName;
          kind_d  = ilt_pkg::KindSection;
          byte_d  = c;
        end
      end
      StSecStart: begin
        if (blank) begin
          state_d = StSecStart;
        end else if (c == ilt_pkg::CharRBracket || eol) begin
          fail = 1'b1;
        end else begin
          state_d = StSecName;
          kind_d  = ilt_pkg::KindSection;
          byte_d  = c;
        end
      end
      StSecName: begin
        if (blank) begin
          state_d = StSecName;
        end else if (c == ilt_pkg::CharRBracket) begin
          state_d = StDone;
          err_d   = 1'b0;
          ev_d    = ilt_pkg::EvSection;
        end else if (eol) begin
          fail = 1'b1;
        end else begin
          kind_d = ilt_pkg::KindSection;
          byte_d = c;
        end
      end
      StKeyStart: begin
        if (blank) begin
          state_d = StKeyStart;
        end else if (c == ilt_pkg::CharRBracket || c == ilt_pkg::CharEquals || eol) begin
          fail = 1'b1;
        end else begin
          state_d = StKey;
          kind_d  = ilt_pkg::KindKey;
          byte_d  = c;
        end
      end
      StKey: begin
        if (blank) begin
          state_d = StKey;
        end else if (c == ilt_pkg::CharEquals) begin
          state_d = StVal;
          ev_d    = ilt_pkg::EvKey;
        end else if (eol) begin
          fail = 1'b1;
        end else begin
          kind_d = ilt_pkg::KindKey;
          byte_d = c;
        end
      end
      StVal: begin
        if (c == ilt_pkg::CharSQuote) begin
          state_d = StValSq;
        end else if (c == ilt_pkg::CharDQuote) begin
          state_d = StValDq;
        end else if (eol) begin
          state_d = StDone;
          err_d   = 1'b0;
          ev_d    = ilt_pkg::EvValue;
        end else if (c == ilt_pkg::CharEquals || blank) begin
          state_d = StVal;
        end else if (c == ilt_pkg::CharComma) begin
          ev_d = ilt_pkg::EvSep;
        end else begin
          kind_d = ilt_pkg::KindValue;
          byte_d = c;
        end
      end
      StValSq, StValDq: begin
        if (eol || (cur_state == StValSq && c == ilt_pkg::CharSQuote) ||
            (cur_state == StValDq && c == ilt_pkg::CharDQuote)) begin
          state_d = StDone;
          ev_d    = ilt_pkg::EvValue;
        end else begin
          kind_d = ilt_pkg::KindValue;
          byte_d = c;
        end
      end
      default: begin
        state_d = StDone;
      end
    endcase
    if (fail) begin
      state_d = StDone;
      err_d   = 1'b1;
      ev_d    = ilt_pkg::EvError;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StDone;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_ready_o) begin
        out_valid_q <= item_valid_i;
      end
      if (fire) begin
        state_q <= state_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      ev_q   <= ev_d;
      done_q <= (state_d == StDone);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = kind_q;
  assign token_byte_o = byte_q;
  assign event_res_o  = ev_q;
  assign line_done_o  = done_q;
  assign error_flag_o = err_q;

endmodule

`default_nettype wire

[design/ini_line_tokenizer.sv]
// INI line tokenizer: takes one byte of a config line per word and gives one result word per
// byte, at one word per cycle while the result channel is not stalled. A byte passes through
// the input register, then the parse decode that feeds the result register; the parse state
// loop lies within the parser, and backpressure on the result channel reaches both stages.
// Depends on ilt_pkg, ilt_in_stage and ilt_parser.
`default_nettype none

module ini_line_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       line_start_i,
  input  wire logic       section_line_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      token_kind_o,
  output logic [7:0]      token_byte_o,
  output logic [2:0]      event_res_o,
  output logic            line_done_o,
  output logic            error_flag_o
);

  ilt_pkg::item_t in_item;
  ilt_pkg::item_t stage_item;
  logic           stage_valid;
  logic           stage_ready;

  assign in_item.char_in      = char_in_i;
  assign in_item.line_start   = line_start_i;
  assign in_item.section_line = section_line_i;

  ilt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (stage_valid),
    .item_ready_i (stage_ready),
    .item_o       (stage_item)
  );

  ilt_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_ready_o (stage_ready),
    .item_i       (stage_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .token_kind_o (token_kind_o),
    .token_byte_o (token_byte_o),
    .event_res_o  (event_res_o),
    .line_done_o  (line_done_o),
    .error_flag_o (error_flag_o)
  );

endmodule

`default_nettype wire

[bench/ini_line_tokenizer_checker.sv]
// Scoreboard for the INI line tokenizer: watches both channels, predicts the result word of
// every accepted byte and compares the results in order. Depends on ilt_pkg.
`timescale 1ns / 1ps

module ini_line_tokenizer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_in_i,
  input  logic       line_start_i,
  input  logic       section_line_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] token_kind_i,
  input  logic [7:0] token_byte_i,
  input  logic [2:0] event_res_i,
  input  logic       line_done_i,
  input  logic       error_flag_i,
  output int         errors_o,
  output int         pending_o
);

  typedef enum logic [3:0] {
    PsDone     = 4'd0,
    PsSecHead  = 4'd2,
    PsSecStart = 4'd3,
    PsSecName  = 4'd4,
    PsKeyStart = 4'd5,
    PsKey      = 4'd6,
    PsVal      = 4'd7,
    PsValSq    = 4'd8,
    PsValDq    = 4'd9
  } parse_state_e;

  typedef struct packed {
    ilt_pkg::token_kind_e kind;
    logic [7:0]           tbyte;
    ilt_pkg::event_e      ev;
    logic                 done;
    logic                 err;
  } token_word_t;

  parse_state_e parse_st = PsDone;
  logic         line_err = 1'b0;
  token_word_t  expected_tokens[$];
  int           mismatches = 0;

  function automatic logic is_eol(input logic [7:0] c);
    return c == ilt_pkg::CharNul || c == ilt_pkg::CharNewline;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == ilt_pkg::CharSpace || c == ilt_pkg::CharTab;
  endfunction

  function automatic token_word_t tokenize_byte(input logic [7:0] c, input logic ls,
                                                input logic sl);
    token_word_t r;
    logic        fail;
    logic        again;
    int          pass;
    r.kind  = ilt_pkg::KindNone;
    r.tbyte = 8'd0;
    r.ev    = ilt_pkg::EvNone;
    fail    = 1'b0;
    again   = 1'b1;
    if (ls) begin
      parse_st = sl ? PsSecHead : PsKeyStart;
      line_err = 1'b0;
    end
    for (pass = 0; pass < 4 && again; pass++) begin
      again = 1'b0;
      case (parse_st)
        PsSecHead: begin
          if (c == ilt_pkg::CharLBracket) begin
          end else if (c == ilt_pkg::CharRBracket || is_eol(c)) begin
            fail = 1'b1;
          end else begin
            parse_st = PsSecStart;
            again = 1'b1;
          end
        end
        PsSecStart: begin
          if (is_blank(c)) begin
          end else if (c == ilt_pkg::CharRBracket || is_eol(c)) begin
            fail = 1'b1;
          end else begin
            parse_st = PsSecName;
            again = 1'b1;
          end
        end
        PsSecName: begin
          if (is_blank(c)) begin
          end else if (c == ilt_pkg::CharRBracket) begin
            parse_st = PsDone;
            line_err = 1'b0;
            r.ev = ilt_pkg::EvSection;
          end else if (is_eol(c)) begin
            fail = 1'b1;
          end else begin
            r.kind = ilt_pkg::KindSection;
            r.tbyte = c;
          end
        end
        PsKeyStart: begin
          if (is_blank(c)) begin
          end else if (c == ilt_pkg::CharRBracket || c == ilt_pkg::CharEquals ||
                       is_eol(c)) begin
            fail = 1'b1;
          end else begin
            parse_st = PsKey;
            again = 1'b1;
          end
        end
        PsKey: begin
          if (is_blank(c)) begin
          end else if (c == ilt_pkg::CharEquals) begin
            parse_st = PsVal;
            r.ev = ilt_pkg::EvKey;
          end else if (is_eol(c)) begin
            fail = 1'b1;
          end else begin
            r.kind = ilt_pkg::KindKey;
            r.tbyte = c;
          end
        end
        PsVal: begin
          if (c == ilt_pkg::CharSQuote) begin
            parse_st = PsValSq;
          end else if (c == ilt_pkg::CharDQuote) begin
            parse_st = PsValDq;
          end else if (is_eol(c)) begin
            parse_st = PsDone;
            line_err = 1'b0;
            r.ev = ilt_pkg::EvValue;
          end else if (c == ilt_pkg::CharEquals || is_blank(c)) begin
          end else if (c == ilt_pkg::CharComma) begin
            r.ev = ilt_pkg::EvSep;
          end else begin
            r.kind = ilt_pkg::KindValue;
            r.tbyte = c;
          end
        end
        PsValSq, PsValDq: begin
          if (is_eol(c) ||
              c == ((parse_st == PsValSq) ? ilt_pkg::CharSQuote : ilt_pkg::CharDQuote)) begin
            parse_st = PsDone;
            r.ev = ilt_pkg::EvValue;
          end else begin
            r.kind = ilt_pkg::KindValue;
            r.tbyte = c;
          end
        end
        default: begin
          parse_st = PsDone;
        end
      endcase
    end
    if (fail) begin
      parse_st = PsDone;
      line_err = 1'b1;
      r.ev = ilt_pkg::EvError;
    end
    r.done = (parse_st == PsDone);
    r.err = line_err;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_word_t want;
    if (!rst_ni) begin
      parse_st = PsDone;
      line_err = 1'b0;
      expected_tokens.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result word: kind %0d byte %02h event %0d done %0b err %0b",
                     token_kind_i, token_byte_i, event_res_i, line_done_i, error_flag_i);
          end
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind_i !== want.kind || token_byte_i !== want.tbyte ||
              event_res_i !== want.ev || line_done_i !== want.done ||
              error_flag_i !== want.err) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected kind %0d byte %02h event %0d done %0b err %0b",
                       want.kind, want.tbyte, want.ev, want.done, want.err);
              $display("          actual   kind %0d byte %02h event %0d done %0b err %0b",
                       token_kind_i, token_byte_i, event_res_i, line_done_i, error_flag_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_tokens.push_back(tokenize_byte(char_in_i, line_start_i, section_line_i));
      end
    end
    errors_o = mismatches;
    pending_o = expected_tokens.size();
  end

endmodule

[bench/ini_line_tokenizer_test.sv]
// Top of the INI line tokenizer testbench: clock, reset, directed and random config lines,
// random gaps on both channels and the final verdict. Depends on ilt_pkg, the tokenizer
// and ini_line_tokenizer_checker.
`timescale 1ns / 1ps

module ini_line_tokenizer_test;

  localparam int CycleLimit = 500000;
  localparam int RandomWords = 850;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] char_in = 8'd0;
  logic       line_start = 1'b0;
  logic       section_line = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] token_kind_o;
  logic [7:0] token_byte_o;
  logic [2:0] event_res_o;
  logic       line_done_o;
  logic       error_flag_o;

  int         mismatch_count;
  int         tokens_pending;
  int         words_sent = 0;
  int         cycles = 0;
  logic       calm = 1'b0;
  logic [7:0] line_bytes[$];
  logic       line_is_section;

  ini_line_tokenizer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in),
    .line_start_i   (line_start),
    .section_line_i (section_line),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind_o),
    .token_byte_o   (token_byte_o),
    .event_res_o    (event_res_o),
    .line_done_o    (line_done_o),
    .error_flag_o   (error_flag_o)
  );

  ini_line_tokenizer_checker scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready_o),
    .char_in_i      (char_in),
    .line_start_i   (line_start),
    .section_line_i (section_line),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready),
    .token_kind_i   (token_kind_o),
    .token_byte_i   (token_byte_o),
    .event_res_i    (event_res_o),
    .line_done_i    (line_done_o),
    .error_flag_i   (error_flag_o),
    .errors_o       (mismatch_count),
    .pending_o      (tokens_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(33, 255));
    end while (c == ilt_pkg::CharEquals || c == ilt_pkg::CharLBracket ||
               c == ilt_pkg::CharRBracket || c == ilt_pkg::CharComma ||
               c == ilt_pkg::CharSQuote || c == ilt_pkg::CharDQuote);
    return c;
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 9))
      0: return ilt_pkg::CharLBracket;
      1: return ilt_pkg::CharRBracket;
      2: return ilt_pkg::CharEquals;
      3: return ilt_pkg::CharComma;
      4: return $urandom_range(0, 1) ? ilt_pkg::CharSQuote : ilt_pkg::CharDQuote;
      5: return $urandom_range(0, 1) ? ilt_pkg::CharSpace : ilt_pkg::CharTab;
      6: return $urandom_range(0, 1) ? ilt_pkg::CharNul : ilt_pkg::CharNewline;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? ilt_pkg::CharSpace : ilt_pkg::CharTab;
  endfunction

  function automatic logic [7:0] eol_char();
    return $urandom_range(0, 1) ? ilt_pkg::CharNul : ilt_pkg::CharNewline;
  endfunction

  task automatic send_word(input logic [7:0] c, input logic ls, input logic sl);
    int unsigned gap;
    in_valid <= 1'b1;
    char_in <= c;
    line_start <= ls;
    section_line <= sl;
    @(posedge clk_i iff in_ready_o);
    words_sent++;
    if ($urandom_range(0, 99) == 0) begin
      calm = ~calm;
    end
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input logic sec);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_word(s[i], i == 0, (i == 0) ? sec : 1'($urandom));
    end
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_bytes.size(); i++) begin
      send_word(line_bytes[i], i == 0, (i == 0) ? line_is_section : 1'($urandom));
    end
  endtask

  task automatic build_value();
    int unsigned mode;
    logic [7:0]  quote;
    mode = $urandom_range(0, 3);
    if (mode < 2) begin
      quote = (mode == 0) ? ilt_pkg::CharSQuote : ilt_pkg::CharDQuote;
      line_bytes.push_back(quote);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0: line_bytes.push_back(blank_char());
          1: line_bytes.push_back((mode == 0) ? ilt_pkg::CharDQuote : ilt_pkg::CharSQuote);
          2: line_bytes.push_back($urandom_range(0, 1) ? ilt_pkg::CharComma
                                                       : ilt_pkg::CharEquals);
          default: line_bytes.push_back(plain_char());
        endcase
      end
      line_bytes.push_back($urandom_range(0, 3) != 0 ? quote : eol_char());
    end else begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 5))
          0: line_bytes.push_back(blank_char());
          1: line_bytes.push_back(ilt_pkg::CharEquals);
          default: line_bytes.push_back(plain_char());
        endcase
      end
    end
  endtask

  task automatic build_line();
    int unsigned pick;
    int unsigned nvals;
    int unsigned keep;
    line_bytes.delete();
    pick = $urandom_range(0, 19);
    line_is_section = 1'($urandom);
    if (pick < 3) begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(any_char());
    end else if (pick < 9) begin
      line_is_section = 1'b1;
      repeat ($urandom_range(0, 2)) line_bytes.push_back(ilt_pkg::CharLBracket);
      repeat ($urandom_range(0, 2)) line_bytes.push_back(blank_char());
      repeat ($urandom_range(1, 6)) begin
        line_bytes.push_back(($urandom_range(0, 4) == 0) ? blank_char() : plain_char());
      end
      line_bytes.push_back(ilt_pkg::CharRBracket);
      repeat ($urandom_range(0, 2)) line_bytes.push_back(any_char());
    end else begin
      line_is_section = 1'b0;
      repeat ($urandom_range(0, 1)) line_bytes.push_back(blank_char());
      line_bytes.push_back(plain_char());
      repeat ($urandom_range(0, 4)) begin
        line_bytes.push_back(($urandom_range(0, 4) == 0) ? blank_char() : plain_char());
      end
      line_bytes.push_back(ilt_pkg::CharEquals);
      nvals = $urandom_range(1, 3);
      for (int v = 0; v < nvals; v++) begin
        if (v != 0) begin
          line_bytes.push_back(ilt_pkg::CharComma);
        end
        build_value();
      end
      line_bytes.push_back(eol_char());
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, line_bytes.size());
      while (line_bytes.size() > keep) void'(line_bytes.pop_back());
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(50, 200)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 9) != 0) begin
          repeat ($urandom_range(1, 3)) @(negedge clk_i);
        end else begin
          repeat ($urandom_range(10, 40)) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // A byte before any line start gives a result word with no token and no event.
    send_word(8'h61, 1'b0, 1'b1);
    send_text("[[ \t\377x]z", 1'b1);
    send_text("]", 1'b1);
    send_text("\n", 1'b1);
    send_text("a", 1'b1);
    send_word(ilt_pkg::CharNul, 1'b0, 1'b0);
    send_text("=", 1'b0);
    send_text("]", 1'b0);
    send_text("k\n", 1'b0);
    send_text("k=a,' c'z", 1'b0);
    send_text("k=\" ", 1'b0);
    send_word(ilt_pkg::CharNul, 1'b0, 1'b1);
    send_text("x=y=\n", 1'b0);

    while (words_sent < RandomWords + 34) begin
      build_line();
      send_line();
    end
    in_valid <= 1'b0;

    while (tokens_pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
